>>> hdl/utg_pkg.sv
// shared types, constants and font folding for the utf8 glyph placer
package utg_pkg;

    localparam int GLYPH_W_MAIN  = 8;
    localparam int GLYPH_W_SMALL = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_FONT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARQUEE_MODE  = 3'd4;

    localparam logic [7:0] CHAR_QMARK = 8'h3F;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int LEVEL_W    = 3;

    typedef struct packed {
        logic signed [10:0] left_x;
        logic signed [11:0] right_limit;
        logic        [11:0] scroll_offset;
        logic               small_font;
        logic               marquee_mode;
    } cfg_t;

    typedef struct packed {
        logic               is_end;
        logic        [7:0]  glyph_index;
        logic signed [13:0] x_pos;
        logic        [7:0]  column_mask;
    } rec_t;

    typedef struct packed {
        logic [1:0] n;
        rec_t       first;
        rec_t       second;
    } push_t;

    function automatic logic [7:0] font_row(input logic [7:0] cp);
        logic [7:0] row;
        if (cp >= 8'd32 && cp <= 8'd126)
            row = cp - 8'd32;
        else if (cp >= 8'd160)
            row = cp - 8'd65;
        else
            row = CHAR_QMARK - 8'd32;
        return row;
    endfunction

endpackage

>>> hdl/utg_place.sv
// utf8 decode, font folding and pen placement, one byte per beat
module utg_place (
    input  logic          clk,
    input  logic          rst_n,
    input  utg_pkg::cfg_t cfg,
    input  logic          beat,
    input  logic [7:0]    text_byte,
    input  logic          last_byte,
    output utg_pkg::push_t push
);
    import utg_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_PAIR, PH_SKIP, PH_STOP} phase_t;

    phase_t             phase_reg, phase_next, phase_cur;
    logic [4:0]         lead_reg, lead_next, lead_cur;
    logic signed [13:0] pen_reg, pen_next, pen_cur;
    logic               open_reg;

    logic signed [14:0] lx15, rl15, sc15, gw15, start15, pen15, pen_end, dl, dr;
    logic [3:0]         gw;
    logic               do_place, clip_stop, placed, emit;
    logic [7:0]         cp, mask_clip, mask_mq, mask;
    logic [10:0]        pair_cp;
    rec_t               glyph_rec, end_rec;

    assign gw   = cfg.small_font ? 4'(GLYPH_W_SMALL) : 4'(GLYPH_W_MAIN);
    assign lx15 = {{4{cfg.left_x[10]}}, cfg.left_x};
    assign rl15 = {{3{cfg.right_limit[11]}}, cfg.right_limit};
    assign sc15 = {3'b000, cfg.scroll_offset};
    assign gw15 = {11'd0, gw};
    assign start15 = cfg.marquee_mode ? (lx15 - sc15) : lx15;

    assign phase_cur = open_reg ? phase_reg : PH_IDLE;
    assign lead_cur  = open_reg ? lead_reg : 5'd0;
    assign pen_cur   = open_reg ? pen_reg : start15[13:0];
    assign pen15     = {pen_cur[13], pen_cur};
    assign pen_end   = pen15 + gw15;
    assign dl        = lx15 - pen15;
    assign dr        = rl15 - pen15;
    assign pair_cp   = {lead_cur, text_byte[5:0]};

    // decode
    always_comb
    begin
        phase_next = phase_cur;
        lead_next  = lead_cur;
        do_place   = 1'b0;
        cp         = CHAR_QMARK;
        unique case (phase_cur)
            PH_PAIR:
            begin
                phase_next = PH_IDLE;
                do_place   = 1'b1;
                if (pair_cp >= 11'd32 && pair_cp <= 11'd255)
                    cp = pair_cp[7:0];
            end
            PH_STOP:
            begin
                phase_next = PH_STOP;
            end
            default:
            begin
                if (phase_cur == PH_SKIP && text_byte[7:6] == 2'b10) begin
                    phase_next = PH_SKIP;
                end else if (text_byte == 8'd0) begin
                    phase_next = PH_STOP;
                end else if (!text_byte[7]) begin
                    phase_next = PH_IDLE;
                    do_place   = 1'b1;
                    if (text_byte >= 8'd32)
                        cp = text_byte;
                end else if (text_byte[7:5] == 3'b110) begin
                    if (last_byte) begin
                        phase_next = PH_IDLE;
                        do_place   = 1'b1;
                    end else begin
                        phase_next = PH_PAIR;
                        lead_next  = text_byte[4:0];
                    end
                end else begin
                    phase_next = PH_SKIP;
                    do_place   = 1'b1;
                end
            end
        endcase
    end

    // column masks
    always_comb
    begin
        for (int c = 0; c < 8; c++) begin
            mask_clip[7-c] = (c < int'(gw));
            mask_mq[7-c]   = (c < int'(gw)) && (int'(dl) <= c) && (int'(dr) > c);
        end
    end

    assign clip_stop = cfg.marquee_mode ? (pen15 >= rl15) : (pen_end > rl15);
    assign placed    = do_place && !clip_stop;
    assign emit      = placed && (!cfg.marquee_mode || (pen_end > lx15));
    assign mask      = cfg.marquee_mode ? mask_mq : mask_clip;
    assign pen_next  = placed ? pen_end[13:0] : pen_cur;

    assign glyph_rec = '{is_end: 1'b0, glyph_index: font_row(cp), x_pos: pen_cur,
                         column_mask: mask};
    assign end_rec   = '{is_end: 1'b1, glyph_index: 8'd0, x_pos: pen_next,
                         column_mask: 8'd0};

    always_comb
    begin
        push.first  = emit ? glyph_rec : end_rec;
        push.second = end_rec;
        if (!beat)
            push.n = 2'd0;
        else if (emit && last_byte)
            push.n = 2'd2;
        else if (emit || last_byte)
            push.n = 2'd1;
        else
            push.n = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            lead_reg  <= 5'd0;
            pen_reg   <= 14'sd0;
            open_reg  <= 1'b0;
        end else if (beat) begin
            pen_reg  <= pen_next;
            open_reg <= !last_byte;
            if (last_byte) begin
                phase_reg <= PH_IDLE;
                lead_reg  <= 5'd0;
            end else begin
                phase_reg <= (do_place && clip_stop) ? PH_STOP : phase_next;
                lead_reg  <= lead_next;
            end
        end
    end

endmodule

>>> hdl/utg_fifo.sv
// result queue taking up to two records per beat and giving one
module utg_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utg_pkg::push_t          push,
    input  logic                    pop,
    output utg_pkg::rec_t           head,
    output logic [utg_pkg::LEVEL_W-1:0] level
);
    import utg_pkg::*;

    rec_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_reg, rd_reg, wr_plus1;
    logic [LEVEL_W-1:0]  level_reg;

    assign wr_plus1 = wr_reg + 1'b1;
    assign head     = mem[rd_reg];
    assign level    = level_reg;

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.n == 2'd2)
            mem[wr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end else begin
            wr_reg    <= wr_reg + FIFO_AW'(push.n);
            rd_reg    <= rd_reg + FIFO_AW'(pop);
            level_reg <= level_reg + LEVEL_W'(push.n) - LEVEL_W'(pop);
        end
    end

endmodule

>>> hdl/utf8_glyph_placer.sv
// top level: utf8 text to latin-1 glyph placement records
//
//  channel  handshake                 payload
//  text     text_valid/text_ready     text_byte, last_byte
//  glyph    glyph_valid/glyph_ready   is_end, glyph_index, x_pos, column_mask
//  cfg      cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one text beat per cycle when text_ready; a beat's glyph and end record leave singly
// the decoder and pen run in the accepting cycle, records are registered in the queue
// a four-entry result queue sets the rate: text_ready drops while more than two wait
// reset clears decode state, pen and queue; registers reload their reset values
// cfg writes are always taken and are registered before the placer uses them
module utf8_glyph_placer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    output logic                           text_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           last_byte,
    output logic                           glyph_valid,
    input  logic                           glyph_ready,
    output logic                           is_end,
    output logic [7:0]                     glyph_index,
    output logic signed [13:0]             x_pos,
    output logic [7:0]                     column_mask,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [utg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [utg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import utg_pkg::*;

    cfg_t               cfg_reg;
    push_t              push;
    rec_t               head;
    logic [LEVEL_W-1:0] level;
    logic               text_beat, glyph_beat;

    assign cfg_ready   = 1'b1;
    assign text_ready  = (level <= LEVEL_W'(FIFO_DEPTH - 2));
    assign text_beat   = text_valid && text_ready;
    assign glyph_valid = (level != '0);
    assign glyph_beat  = glyph_valid && glyph_ready;

    assign is_end      = head.is_end;
    assign glyph_index = head.glyph_index;
    assign x_pos       = head.x_pos;
    assign column_mask = head.column_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_x        <= 11'sd0;
            cfg_reg.right_limit   <= 12'sd320;
            cfg_reg.scroll_offset <= 12'd0;
            cfg_reg.small_font    <= 1'b0;
            cfg_reg.marquee_mode  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEFT_X:        cfg_reg.left_x        <= cfg_data[10:0];
                CFG_RIGHT_LIMIT:   cfg_reg.right_limit   <= cfg_data;
                CFG_SCROLL_OFFSET: cfg_reg.scroll_offset <= cfg_data;
                CFG_SMALL_FONT:    cfg_reg.small_font    <= cfg_data[0];
                CFG_MARQUEE_MODE:  cfg_reg.marquee_mode  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    utg_place u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .beat      (text_beat),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .push      (push)
    );

    utg_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (glyph_beat),
        .head  (head),
        .level (level)
    );

    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (text_beat && last_byte) |=> glyph_valid)
        else $error("end record missing after last beat");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LEVEL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> glyph_valid)
        else $error("input stalled with empty queue");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (text_beat && last_byte))
        else $error("double record without last beat");

endmodule

>>> verif/tb_utf8_glyph_placer.sv
// utf8_glyph_placer testbench: directed byte table, then random strings under many register settings
module tb_utf8_glyph_placer;
    timeunit 1ns;
    timeprecision 1ps;
    import utg_pkg::*;

    localparam int N_PHASES        = 12;
    localparam int BEATS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_WAIT        = 5;

    localparam logic [7:0] NUL_BYTE   = 8'h00;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] ASCII_END  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam logic [7:0] LATIN_LO   = 8'd160;
    localparam logic [7:0] LATIN_ROW0 = 8'd95;

    typedef enum logic [1:0] {DEC_IDLE, DEC_PAIR, DEC_SKIP, DEC_STOP} dec_phase_e;

    typedef struct packed {
        logic [7:0] tbyte;
        logic       lb;
        logic       fixed;
        logic [1:0] n_fixed;
        rec_t       r0;
        rec_t       r1;
    } text_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  text_valid = 1'b0;
    logic                  text_ready;
    logic [7:0]            text_byte = 8'h00;
    logic                  last_byte = 1'b0;
    logic                  glyph_valid;
    logic                  glyph_ready = 1'b0;
    logic                  is_end;
    logic [7:0]            glyph_index;
    logic signed [13:0]    x_pos;
    logic [7:0]            column_mask;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register mirror and decoder/pen state
    cfg_t       cfg_mirror;
    dec_phase_e dec_phase = DEC_IDLE;
    logic [4:0] lead_bits = '0;
    int         pen = 0;
    bit         str_open = 1'b0;

    rec_t      beat_recs[$];
    rec_t      pending_recs[$];
    text_row_t text_q[$];
    text_row_t dir_rows[$];

    rec_t got_rec, want_rec;
    int   out_wait = 0;
    bit   steady = 1'b0;
    int   errors = 0;
    int   beats_in = 0;
    int   glyph_recs = 0;
    int   end_recs = 0;

    utf8_glyph_placer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .last_byte   (last_byte),
        .glyph_valid (glyph_valid),
        .glyph_ready (glyph_ready),
        .is_end      (is_end),
        .glyph_index (glyph_index),
        .x_pos       (x_pos),
        .column_mask (column_mask),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] latin_row(input logic [7:0] cp);
        if (cp >= SPACE_BYTE && cp <= PRINT_HI)
            return cp - SPACE_BYTE;
        if (cp >= LATIN_LO)
            return cp - LATIN_LO + LATIN_ROW0;
        return CHAR_QMARK - SPACE_BYTE;
    endfunction

    function automatic rec_t glyph_rec(input logic [7:0] row, input int x, input logic [7:0] m);
        rec_t r;
        r.is_end      = 1'b0;
        r.glyph_index = row;
        r.x_pos       = x[13:0];
        r.column_mask = m;
        return r;
    endfunction

    function automatic rec_t end_rec(input int x);
        rec_t r;
        r             = '0;
        r.is_end      = 1'b1;
        r.x_pos       = x[13:0];
        return r;
    endfunction

    function automatic text_row_t beat_row(input logic [7:0] b, input logic l);
        text_row_t t;
        t       = '0;
        t.tbyte = b;
        t.lb    = l;
        return t;
    endfunction

    function automatic text_row_t typed_row(input logic [7:0] b, input logic l,
                                            input logic [1:0] n, input rec_t r0, input rec_t r1);
        text_row_t t;
        t         = beat_row(b, l);
        t.fixed   = 1'b1;
        t.n_fixed = n;
        t.r0      = r0;
        t.r1      = r1;
        return t;
    endfunction

    task automatic place_glyph(input logic [7:0] cp);
        int         gw, lx, rl, c;
        logic [7:0] mask;
        bit         shown;
        gw    = cfg_mirror.small_font ? GLYPH_W_SMALL : GLYPH_W_MAIN;
        lx    = int'($signed(cfg_mirror.left_x));
        rl    = int'($signed(cfg_mirror.right_limit));
        mask  = '0;
        shown = 1'b1;
        if (!cfg_mirror.marquee_mode)
        begin
            if (pen + gw > rl)
            begin
                dec_phase = DEC_STOP;
                return;
            end
            mask = 8'hFF << (8 - gw);
        end
        else
        begin
            if (pen >= rl)
            begin
                dec_phase = DEC_STOP;
                return;
            end
            if (pen + gw > lx)
            begin
                for (c = 0; c < gw; c++)
                    if (pen + c >= lx && pen + c < rl)
                        mask[7-c] = 1'b1;
            end
            else
                shown = 1'b0;
        end
        if (shown)
            beat_recs.push_back(glyph_rec(latin_row(cp), pen, mask));
        pen += gw;
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic l);
        logic [10:0] cp;
        int          lx;
        beat_recs.delete();
        if (!str_open)
        begin
            lx = int'($signed(cfg_mirror.left_x));
            pen = cfg_mirror.marquee_mode ? lx - int'(cfg_mirror.scroll_offset) : lx;
            str_open  = 1'b1;
            dec_phase = DEC_IDLE;
            lead_bits = '0;
        end
        if (dec_phase == DEC_PAIR)
        begin
            cp = {lead_bits, b[5:0]};
            dec_phase = DEC_IDLE;
            place_glyph((cp >= 11'd32 && cp <= 11'd255) ? cp[7:0] : CHAR_QMARK);
        end
        else if (dec_phase != DEC_STOP)
        begin
            // continuations after a long or stray lead are swallowed
            if (!(dec_phase == DEC_SKIP && (b & CONT_MASK) == CONT_TAG))
            begin
                if (b == NUL_BYTE)
                    dec_phase = DEC_STOP;
                else if (b < ASCII_END)
                begin
                    dec_phase = DEC_IDLE;
                    place_glyph(b >= SPACE_BYTE ? b : CHAR_QMARK);
                end
                else if ((b & LEAD2_MASK) == LEAD2_TAG)
                begin
                    if (l)
                    begin
                        dec_phase = DEC_IDLE;
                        place_glyph(CHAR_QMARK);
                    end
                    else
                    begin
                        dec_phase = DEC_PAIR;
                        lead_bits = b[4:0];
                    end
                end
                else
                begin
                    dec_phase = DEC_SKIP;
                    place_glyph(CHAR_QMARK);
                end
            end
        end
        if (l)
        begin
            beat_recs.push_back(end_rec(pen));
            dec_phase = DEC_IDLE;
            lead_bits = '0;
            str_open  = 1'b0;
        end
    endtask

    task automatic send_beat(input text_row_t t);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= t.tbyte;
        last_byte  <= t.lb;
        do @(posedge clk); while (!text_ready);
        predict_beat(t.tbyte, t.lb);
        beats_in++;
        if (t.fixed)
        begin
            if (t.n_fixed > 0)
                pending_recs.push_back(t.r0);
            if (t.n_fixed > 1)
                pending_recs.push_back(t.r1);
        end
        else
            foreach (beat_recs[j])
                pending_recs.push_back(beat_recs[j]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_LEFT_X:        cfg_mirror.left_x        = data[10:0];
            CFG_RIGHT_LIMIT:   cfg_mirror.right_limit   = data;
            CFG_SCROLL_OFFSET: cfg_mirror.scroll_offset = data;
            CFG_SMALL_FONT:    cfg_mirror.small_font    = data[0];
            CFG_MARQUEE_MODE:  cfg_mirror.marquee_mode  = data[0];
            default: ;
        endcase
    endtask

    task automatic settle();
        text_valid <= 1'b0;
        while (pending_recs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_phase(input int ph);
        int          lx, rl, sc;
        logic        sf, mq;
        logic [11:0] junk;
        junk = 12'($urandom());
        case (ph)
            0:
            begin
                lx = -1024; rl = -1024; sc = 0;    sf = 1'b0; mq = 1'b0;
            end
            1:
            begin
                lx = 1023;  rl = 2047;  sc = 4095; sf = 1'b1; mq = 1'b1;
            end
            2:
            begin
                lx = -1024; rl = 2047;  sc = 0;    sf = 1'b0; mq = 1'b1;
            end
            3:
            begin
                lx = 200;   rl = 150;   sc = 5;    sf = 1'b1; mq = 1'b1;
            end
            4:
            begin
                lx = 1023;  rl = 2047;  sc = 4095; sf = 1'b0; mq = 1'b0;
            end
            5:
            begin
                lx = 0;     rl = 17;    sc = 0;    sf = 1'b1; mq = 1'b0;
            end
            default:
            begin
                lx = $urandom_range(0, 2047) - 1024;
                if ($urandom_range(0, 9) == 0)
                    rl = $urandom_range(0, 4095) - 2048;
                else
                    rl = lx + $urandom_range(0, 440) - 40;
                if (rl > 2047)
                    rl = 2047;
                if (rl < -1024)
                    rl = -1024;
                case ($urandom_range(0, 3))
                    0: sc = 0;
                    1: sc = $urandom_range(0, 4095);
                    default: sc = $urandom_range(0, 40);
                endcase
                sf = 1'($urandom_range(0, 1));
                mq = 1'($urandom_range(0, 1));
            end
        endcase
        write_reg(CFG_LEFT_X, {junk[11], lx[10:0]});
        write_reg(CFG_RIGHT_LIMIT, rl[11:0]);
        write_reg(CFG_SCROLL_OFFSET, sc[11:0]);
        write_reg(CFG_SMALL_FONT, {junk[11:1], sf});
        write_reg(CFG_MARQUEE_MODE, {junk[10:0], mq});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_MARQUEE_MODE + CFG_IDX_W'($urandom_range(1, 3)), junk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        text_q.push_back(beat_row(b, 1'b0));
    endtask

    task automatic queue_string(input int n_chars, input bit close);
        int k;
        repeat (n_chars)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
                push_byte(8'($urandom_range(32, 127)));
            else if (k < 50)
                push_byte(8'($urandom_range(1, 31)));
            else if (k < 68)
            begin
                push_byte(8'($urandom_range(8'hC2, 8'hC3)));
                push_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (k < 73)
            begin
                push_byte(8'($urandom_range(8'hC0, 8'hDF)));
                push_byte(8'($urandom_range(0, 255)));
            end
            else if (k < 80)
            begin
                push_byte(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) push_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (k < 84)
            begin
                push_byte(8'($urandom_range(8'hF0, 8'hF7)));
                repeat (3) push_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (k < 88)
                push_byte(8'($urandom_range(8'h80, 8'hBF)));
            else if (k < 91)
                push_byte(8'($urandom_range(8'hF8, 8'hFF)));
            else if (k < 93)
                push_byte(NUL_BYTE);
            else if (k < 96)
                push_byte(8'($urandom_range(8'hC0, 8'hDF)));
            else
                push_byte(8'($urandom_range(0, 255)));
        end
        if (close)
            text_q[text_q.size()-1].lb = 1'b1;
    endtask

    // result side: check each beat, stall ready at random unless steady is set
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (glyph_valid && glyph_ready)
            begin
                got_rec = '{is_end, glyph_index, x_pos, column_mask};
                if (pending_recs.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected beat: end=%0d row=%0d x=%0d mask=%02h", $time,
                             got_rec.is_end, got_rec.glyph_index, $signed(got_rec.x_pos),
                             got_rec.column_mask);
                end
                else
                begin
                    want_rec = pending_recs.pop_front();
                    if (got_rec.is_end !== want_rec.is_end
                        || got_rec.glyph_index !== want_rec.glyph_index
                        || got_rec.x_pos !== want_rec.x_pos
                        || got_rec.column_mask !== want_rec.column_mask)
                    begin
                        errors++;
                        $display("%0t mismatch: expected end=%0d row=%0d x=%0d mask=%02h",
                                 $time, want_rec.is_end, want_rec.glyph_index,
                                 $signed(want_rec.x_pos), want_rec.column_mask);
                        $display("%0t            actual end=%0d row=%0d x=%0d mask=%02h",
                                 $time, got_rec.is_end, got_rec.glyph_index,
                                 $signed(got_rec.x_pos), got_rec.column_mask);
                    end
                    if (want_rec.is_end)
                        end_recs++;
                    else
                        glyph_recs++;
                end
                out_wait = draw_wait();
            end
            else if (out_wait > 0)
                out_wait--;
            glyph_ready <= (out_wait == 0);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_utf8_glyph_placer NOT OK");
        $finish;
    end

    initial
    begin
        int ph, ph_start;
        cfg_mirror.left_x        = '0;
        cfg_mirror.right_limit   = 12'sd320;
        cfg_mirror.scroll_offset = '0;
        cfg_mirror.small_font    = 1'b0;
        cfg_mirror.marquee_mode  = 1'b0;

        // reset config: clip mode, main font, window 0..320
        dir_rows.push_back(typed_row(8'h41, 1'b0, 2'd1, glyph_rec(8'd33, 0, 8'hFF), '0));
        dir_rows.push_back(typed_row(8'h7E, 1'b0, 2'd1, glyph_rec(8'd94, 8, 8'hFF), '0));
        dir_rows.push_back(typed_row(8'h1F, 1'b0, 2'd1, glyph_rec(8'd31, 16, 8'hFF), '0));
        dir_rows.push_back(typed_row(8'hC3, 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(typed_row(8'hBF, 1'b0, 2'd1, glyph_rec(8'd190, 24, 8'hFF), '0));
        dir_rows.push_back(beat_row(8'hC2, 1'b0));
        dir_rows.push_back(beat_row(8'h80, 1'b0));
        dir_rows.push_back(beat_row(8'hC0, 1'b0));
        dir_rows.push_back(beat_row(8'h81, 1'b0));
        dir_rows.push_back(beat_row(8'hC5, 1'b0));
        dir_rows.push_back(beat_row(8'h41, 1'b0));
        dir_rows.push_back(beat_row(8'hC3, 1'b0));
        dir_rows.push_back(beat_row(8'h00, 1'b0));
        dir_rows.push_back(typed_row(8'hE2, 1'b0, 2'd1, glyph_rec(8'd31, 64, 8'hFF), '0));
        dir_rows.push_back(beat_row(8'h82, 1'b0));
        dir_rows.push_back(beat_row(8'hAC, 1'b0));
        dir_rows.push_back(beat_row(8'h20, 1'b0));
        dir_rows.push_back(beat_row(8'hF0, 1'b0));
        dir_rows.push_back(beat_row(8'hFF, 1'b0));
        dir_rows.push_back(beat_row(8'h80, 1'b0));
        dir_rows.push_back(beat_row(8'h7F, 1'b0));
        dir_rows.push_back(beat_row(8'hA0, 1'b0));
        dir_rows.push_back(typed_row(8'hC3, 1'b1, 2'd2, glyph_rec(8'd31, 112, 8'hFF),
                                     end_rec(120)));
        dir_rows.push_back(typed_row(8'h00, 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(typed_row(8'h41, 1'b1, 2'd1, end_rec(0), '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i]);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            program_phase(ph);
            steady = (ph % 4 == 3);
            ph_start = beats_in;
            while (beats_in - ph_start < BEATS_PER_PHASE)
            begin
                text_q.delete();
                if ($urandom_range(0, 19) == 0)
                    text_q.push_back(beat_row(8'($urandom_range(0, 255)),
                                              1'($urandom_range(0, 1))));
                else
                    queue_string($urandom_range(1, 24), 1'b1);
                foreach (text_q[i])
                    send_beat(text_q[i]);
            end
            // leave a string open so the next register writes land mid-string
            if ($urandom_range(0, 1))
            begin
                text_q.delete();
                queue_string($urandom_range(1, 5), 1'b0);
                foreach (text_q[i])
                    send_beat(text_q[i]);
            end
        end
        settle();

        $display("%0d text beats across %0d register settings (clip, marquee, empty window)",
                 beats_in, N_PHASES + 1);
        $display("%0d glyph records and %0d end records compared, %0d mismatches",
                 glyph_recs, end_recs, errors);
        if (errors == 0)
            $display("tb_utf8_glyph_placer OK");
        else
            $display("tb_utf8_glyph_placer NOT OK");
        $finish;
    end

endmodule
